// ----- design/surface_normal_unit_defines.svh -----
// Assertion macros used by the checker file of the surface normal unit.
`ifndef SURFACE_NORMAL_UNIT_DEFINES_SVH
`define SURFACE_NORMAL_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SNU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SNU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/snu_pkg.sv -----
// Shared widths, codes and sideband types of the surface normal unit.
package snu_pkg;

    // Field and datapath widths.
    localparam int IN_W       = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NORM_SHIFT = 30;
    localparam int PROD_W     = 64;
    localparam int MAG_W      = 63;
    localparam int HALF_W     = 32;
    localparam int SQ_W       = 128;
    localparam int ROOT_W     = 64;
    localparam int REM_W      = 67;
    localparam int DIV_R_W    = 65;
    localparam int QUO_W      = 31;
    localparam int AREA_W     = 31;
    localparam int NORM_W     = 32;
    localparam int LANES      = 3;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = QUO_W;

    // Dimension register codes.
    localparam logic [1:0] DIM_2D    = 2'd2;
    localparam logic [1:0] DIM_3D    = 2'd3;
    localparam logic [1:0] DIM_RESET = DIM_3D;

    // Output constants.
    localparam logic [AREA_W-1:0] AREA_MAX = '1;
    localparam logic [AREA_W-1:0] AREA_ONE = AREA_W'(64'd1 << FRAC_BITS);
    localparam logic [NORM_W-1:0] NORM_MINUS_ONE = NORM_W'(-(longint'(1) << NORM_SHIFT));

    // Sideband carried along the square-root chain.
    typedef struct packed {
        logic [LANES-1:0]            neg;
        logic [LANES-1:0][MAG_W-1:0] mag;
        logic                        eob;
    } sqrt_side_t;

    // Sideband carried along the divider chain.
    typedef struct packed {
        logic [LANES-1:0]  neg;
        logic [ROOT_W-1:0] len;
        logic              eob;
    } div_side_t;

endpackage

// ----- design/snu_sqrt_cell.sv -----
// One restoring square-root step: two radicand bits in, one root bit out.
module snu_sqrt_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      prev_valid,
    input  logic [snu_pkg::SQ_W-1:0]  prev_rad,
    input  logic [snu_pkg::REM_W-1:0] prev_rem,
    input  logic [snu_pkg::ROOT_W-1:0] prev_root,
    input  snu_pkg::sqrt_side_t       prev_side,
    output logic                      cell_valid,
    output logic [snu_pkg::SQ_W-1:0]  cell_rad,
    output logic [snu_pkg::REM_W-1:0] cell_rem,
    output logic [snu_pkg::ROOT_W-1:0] cell_root,
    output snu_pkg::sqrt_side_t       cell_side
);

    logic                       valid_reg;
    logic [snu_pkg::SQ_W-1:0]   rad_reg;
    logic [snu_pkg::REM_W-1:0]  rem_reg;
    logic [snu_pkg::REM_W-1:0]  rem_next;
    logic [snu_pkg::ROOT_W-1:0] root_reg;
    logic [snu_pkg::ROOT_W-1:0] root_next;
    snu_pkg::sqrt_side_t        side_reg;
    logic [snu_pkg::REM_W-1:0]  rem_sh;
    logic [snu_pkg::REM_W-1:0]  trial;
    logic                       ge;

    // Bring down two radicand bits and try the root bit.
    always_comb
    begin
        rem_sh    = {prev_rem[snu_pkg::REM_W-3:0], prev_rad[snu_pkg::SQ_W-1 -: 2]};
        trial     = {{(snu_pkg::REM_W-snu_pkg::ROOT_W-2){1'b0}}, prev_root, 2'b01};
        ge        = (rem_sh >= trial);
        rem_next  = ge ? (rem_sh - trial) : rem_sh;
        root_next = {prev_root[snu_pkg::ROOT_W-2:0], ge};
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= prev_valid;
    end

    // Step payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg  <= prev_rad << 2;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= prev_side;
        end
    end

    assign cell_valid = valid_reg;
    assign cell_rad   = rad_reg;
    assign cell_rem   = rem_reg;
    assign cell_root  = root_reg;
    assign cell_side  = side_reg;

endmodule

// ----- design/snu_div_cell.sv -----
// One restoring division step for all three normal components.
module snu_div_cell (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             adv,
    input  logic                                             prev_valid,
    input  logic [snu_pkg::LANES-1:0][snu_pkg::DIV_R_W-1:0]  prev_r,
    input  logic [snu_pkg::LANES-1:0][snu_pkg::QUO_W-1:0]    prev_q,
    input  snu_pkg::div_side_t                               prev_side,
    output logic                                             cell_valid,
    output logic [snu_pkg::LANES-1:0][snu_pkg::DIV_R_W-1:0]  cell_r,
    output logic [snu_pkg::LANES-1:0][snu_pkg::QUO_W-1:0]    cell_q,
    output snu_pkg::div_side_t                               cell_side
);

    logic                                            valid_reg;
    logic [snu_pkg::LANES-1:0][snu_pkg::DIV_R_W-1:0] r_reg;
    logic [snu_pkg::LANES-1:0][snu_pkg::DIV_R_W-1:0] r_next;
    logic [snu_pkg::LANES-1:0][snu_pkg::QUO_W-1:0]   q_reg;
    logic [snu_pkg::LANES-1:0][snu_pkg::QUO_W-1:0]   q_next;
    snu_pkg::div_side_t                              side_reg;
    logic [snu_pkg::DIV_R_W-1:0]                     len_ext;
    logic [snu_pkg::LANES-1:0][snu_pkg::DIV_R_W-1:0] kept;
    logic [snu_pkg::LANES-1:0]                       ge;

    // Compare each partial remainder with the length, subtract and shift.
    always_comb
    begin
        len_ext = {1'b0, prev_side.len};
        for (int l = 0; l < snu_pkg::LANES; l++)
        begin
            ge[l]     = (prev_r[l] >= len_ext);
            kept[l]   = ge[l] ? (prev_r[l] - len_ext) : prev_r[l];
            r_next[l] = {kept[l][snu_pkg::ROOT_W-1:0], 1'b0};
            q_next[l] = {prev_q[l][snu_pkg::QUO_W-2:0], ge[l]};
        end
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= prev_valid;
    end

    // Step payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg    <= r_next;
            q_reg    <= q_next;
            side_reg <= prev_side;
        end
    end

    assign cell_valid = valid_reg;
    assign cell_r     = r_reg;
    assign cell_q     = q_reg;
    assign cell_side  = side_reg;

endmodule

// ----- design/surface_normal_unit.sv -----
// Top level of the surface normal unit: cross product, square-root and divider cell chains.
//
//  channel   signals                              transaction when
//  item      item_valid / item_ready, tangents    item_valid && item_ready
//  result    result_valid / result_ready, fields  result_valid && result_ready
//  config    cfg_write_enable / cfg_data          cfg_write_enable
//
// One item enters per cycle while the pipeline advances. The stages are six front stages, a chain of 64
// square-root cells (one root bit each) and 31 divider cells (one quotient bit each),
// then the result register. Reset clears all valid bits and sets dimension to 3.
// When the result register is held and the last divider cell is full, the whole
// pipeline freezes; a bubble at the end of the chain still lets new items in.
module surface_normal_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_enable,
    input  logic [1:0]                         cfg_data,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic signed [snu_pkg::IN_W-1:0]    tangent_a_x,
    input  logic signed [snu_pkg::IN_W-1:0]    tangent_a_y,
    input  logic signed [snu_pkg::IN_W-1:0]    tangent_a_z,
    input  logic signed [snu_pkg::IN_W-1:0]    tangent_b_x,
    input  logic signed [snu_pkg::IN_W-1:0]    tangent_b_y,
    input  logic signed [snu_pkg::IN_W-1:0]    tangent_b_z,
    input  logic                               end_of_batch,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic [snu_pkg::AREA_W-1:0]         area_scale,
    output logic signed [snu_pkg::NORM_W-1:0]  normal_x,
    output logic signed [snu_pkg::NORM_W-1:0]  normal_y,
    output logic signed [snu_pkg::NORM_W-1:0]  normal_z,
    output logic                               degenerate,
    output logic                               saturated,
    output logic                               end_of_batch_out
);

    localparam int SQ = snu_pkg::SQRT_STEPS;
    localparam int DV = snu_pkg::DIV_STEPS;
    localparam int PW = snu_pkg::PROD_W;

    logic [1:0] dimension_reg;
    logic       adv;
    logic       out_free;

    // Front stage registers.
    logic                        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                        s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic signed [PW-1:0]        prod_reg [6];
    logic signed [snu_pkg::IN_W-1:0] ax_reg, ay_reg;
    logic                        s1_eob_reg, s2_eob_reg;
    logic [snu_pkg::LANES-1:0][PW-1:0] v_reg;
    logic [snu_pkg::LANES-1:0][PW-1:0] v_next;
    snu_pkg::sqrt_side_t         s3_side_reg, s4_side_reg, s5_side_reg, s6_side_reg;
    snu_pkg::sqrt_side_t         s3_side_next;
    logic [snu_pkg::LANES-1:0][PW-1:0] pll_reg, plh_reg, phh_reg;
    logic [snu_pkg::LANES-1:0][snu_pkg::SQ_W-1:0] sq_reg;
    logic [snu_pkg::SQ_W-1:0]    sum_reg;
    logic [snu_pkg::LANES-1:0][PW-1:0] absv;

    // Chain links.
    logic                         sr_valid [SQ+1];
    logic [snu_pkg::SQ_W-1:0]     sr_rad   [SQ+1];
    logic [snu_pkg::REM_W-1:0]    sr_rem   [SQ+1];
    logic [snu_pkg::ROOT_W-1:0]   sr_root  [SQ+1];
    snu_pkg::sqrt_side_t          sr_side  [SQ+1];
    logic                         dv_valid [DV+1];
    logic [snu_pkg::LANES-1:0][snu_pkg::DIV_R_W-1:0] dv_r [DV+1];
    logic [snu_pkg::LANES-1:0][snu_pkg::QUO_W-1:0]   dv_q [DV+1];
    snu_pkg::div_side_t           dv_side  [DV+1];

    // Result register.
    logic                                result_valid_reg;
    logic [snu_pkg::AREA_W-1:0]          area_reg, area_next;
    logic [snu_pkg::LANES-1:0][snu_pkg::NORM_W-1:0] norm_reg, norm_next;
    logic                                deg_reg, deg_next;
    logic                                sat_reg, sat_next;
    logic                                eob_reg;
    logic [snu_pkg::ROOT_W-1:0]          area_full;
    logic [snu_pkg::NORM_W-1:0]          q_ext;

    // Flow control: the chain moves unless a finished result is blocked behind a held one.
    assign out_free   = !result_valid_reg || result_ready;
    assign adv        = out_free || !dv_valid[DV];
    assign item_ready = adv;

    // Dimension register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dimension_reg <= snu_pkg::DIM_RESET;
        else if (cfg_write_enable)
            dimension_reg <= cfg_data;
    end

    // Front valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= item_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    // Direction vector: cross product in 3D, rotated tangent in 2D.
    always_comb
    begin
        if (dimension_reg == snu_pkg::DIM_3D)
        begin
            v_next[0] = PW'(prod_reg[0] - prod_reg[1]);
            v_next[1] = PW'(prod_reg[2] - prod_reg[3]);
            v_next[2] = PW'(prod_reg[4] - prod_reg[5]);
        end
        else
        begin
            v_next[0] = PW'(ay_reg);
            v_next[1] = PW'(-(PW'(ax_reg)));
            v_next[2] = '0;
        end
    end

    // Sign and magnitude of each component.
    always_comb
    begin
        s3_side_next.eob = s2_eob_reg;
        for (int l = 0; l < snu_pkg::LANES; l++)
        begin
            s3_side_next.neg[l] = v_reg[l][PW-1];
            absv[l]             = v_reg[l][PW-1] ? (PW'(0) - v_reg[l]) : v_reg[l];
            s3_side_next.mag[l] = absv[l][snu_pkg::MAG_W-1:0];
        end
    end

    // Front pipeline payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Stage 1: the six tangent products.
            prod_reg[0] <= PW'(tangent_a_y) * PW'(tangent_b_z);
            prod_reg[1] <= PW'(tangent_a_z) * PW'(tangent_b_y);
            prod_reg[2] <= PW'(tangent_a_z) * PW'(tangent_b_x);
            prod_reg[3] <= PW'(tangent_a_x) * PW'(tangent_b_z);
            prod_reg[4] <= PW'(tangent_a_x) * PW'(tangent_b_y);
            prod_reg[5] <= PW'(tangent_a_y) * PW'(tangent_b_x);
            ax_reg      <= tangent_a_x;
            ay_reg      <= tangent_a_y;
            s1_eob_reg  <= end_of_batch;
            // Stage 2: direction vector.
            v_reg      <= v_next;
            s2_eob_reg <= s1_eob_reg;
            // Stage 3: magnitudes.
            s3_side_reg <= s3_side_next;
            // Stage 4: 32-bit partial products of each square.
            for (int l = 0; l < snu_pkg::LANES; l++)
            begin
                pll_reg[l] <= PW'(s3_side_reg.mag[l][snu_pkg::HALF_W-1:0])
                            * PW'(s3_side_reg.mag[l][snu_pkg::HALF_W-1:0]);
                plh_reg[l] <= PW'(s3_side_reg.mag[l][snu_pkg::HALF_W-1:0])
                            * PW'(s3_side_reg.mag[l][snu_pkg::MAG_W-1:snu_pkg::HALF_W]);
                phh_reg[l] <= PW'(s3_side_reg.mag[l][snu_pkg::MAG_W-1:snu_pkg::HALF_W])
                            * PW'(s3_side_reg.mag[l][snu_pkg::MAG_W-1:snu_pkg::HALF_W]);
            end
            s4_side_reg <= s3_side_reg;
            // Stage 5: each square.
            for (int l = 0; l < snu_pkg::LANES; l++)
            begin
                sq_reg[l] <= (snu_pkg::SQ_W'(phh_reg[l]) << (2 * snu_pkg::HALF_W))
                           + (snu_pkg::SQ_W'(plh_reg[l]) << (snu_pkg::HALF_W + 1))
                           + snu_pkg::SQ_W'(pll_reg[l]);
            end
            s5_side_reg <= s4_side_reg;
            // Stage 6: squared length.
            sum_reg     <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            s6_side_reg <= s5_side_reg;
        end
    end

    // Square-root chain.
    assign sr_valid[0] = s6_valid_reg;
    assign sr_rad[0]   = sum_reg;
    assign sr_rem[0]   = '0;
    assign sr_root[0]  = '0;
    assign sr_side[0]  = s6_side_reg;

    for (genvar i = 0; i < SQ; i++)
    begin : g_sqrt
        snu_sqrt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .prev_valid (sr_valid[i]),
            .prev_rad   (sr_rad[i]),
            .prev_rem   (sr_rem[i]),
            .prev_root  (sr_root[i]),
            .prev_side  (sr_side[i]),
            .cell_valid (sr_valid[i+1]),
            .cell_rad   (sr_rad[i+1]),
            .cell_rem   (sr_rem[i+1]),
            .cell_root  (sr_root[i+1]),
            .cell_side  (sr_side[i+1])
        );
    end

    // Divider chain: each component magnitude over the length.
    assign dv_valid[0]    = sr_valid[SQ];
    assign dv_side[0].neg = sr_side[SQ].neg;
    assign dv_side[0].eob = sr_side[SQ].eob;
    assign dv_side[0].len = sr_root[SQ];

    for (genvar l = 0; l < snu_pkg::LANES; l++)
    begin : g_div_init
        assign dv_r[0][l] = {{(snu_pkg::DIV_R_W-snu_pkg::MAG_W){1'b0}}, sr_side[SQ].mag[l]};
        assign dv_q[0][l] = '0;
    end

    for (genvar i = 0; i < DV; i++)
    begin : g_div
        snu_div_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .prev_valid (dv_valid[i]),
            .prev_r     (dv_r[i]),
            .prev_q     (dv_q[i]),
            .prev_side  (dv_side[i]),
            .cell_valid (dv_valid[i+1]),
            .cell_r     (dv_r[i+1]),
            .cell_q     (dv_q[i+1]),
            .cell_side  (dv_side[i+1])
        );
    end

    // Result selection by face rule, degenerate length and saturation.
    always_comb
    begin
        area_full = (dimension_reg == snu_pkg::DIM_3D)
                  ? (dv_side[DV].len >> snu_pkg::FRAC_BITS) : dv_side[DV].len;
        q_ext     = '0;
        area_next = '0;
        norm_next = '0;
        deg_next  = 1'b0;
        sat_next  = 1'b0;
        if (dimension_reg != snu_pkg::DIM_2D && dimension_reg != snu_pkg::DIM_3D)
        begin
            area_next    = snu_pkg::AREA_ONE;
            norm_next[0] = snu_pkg::NORM_MINUS_ONE;
        end
        else if (dv_side[DV].len == '0)
        begin
            deg_next = 1'b1;
        end
        else
        begin
            sat_next  = (area_full > snu_pkg::ROOT_W'(snu_pkg::AREA_MAX));
            area_next = sat_next ? snu_pkg::AREA_MAX : area_full[snu_pkg::AREA_W-1:0];
            for (int l = 0; l < snu_pkg::LANES; l++)
            begin
                q_ext        = snu_pkg::NORM_W'(dv_q[DV][l]);
                norm_next[l] = dv_side[DV].neg[l] ? (snu_pkg::NORM_W'(0) - q_ext) : q_ext;
            end
        end
    end

    // Result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (out_free)
            result_valid_reg <= dv_valid[DV];
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (out_free && dv_valid[DV])
        begin
            area_reg <= area_next;
            norm_reg <= norm_next;
            deg_reg  <= deg_next;
            sat_reg  <= sat_next;
            eob_reg  <= dv_side[DV].eob;
        end
    end

    assign result_valid     = result_valid_reg;
    assign area_scale       = area_reg;
    assign normal_x         = norm_reg[0];
    assign normal_y         = norm_reg[1];
    assign normal_z         = norm_reg[2];
    assign degenerate       = deg_reg;
    assign saturated        = sat_reg;
    assign end_of_batch_out = eob_reg;

endmodule

// ----- design/snu_checker.sv -----
// Port-level checks of the surface normal unit and their binding to the top level.
`include "surface_normal_unit_defines.svh"

module snu_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic [snu_pkg::AREA_W-1:0]        area_scale,
    input logic signed [snu_pkg::NORM_W-1:0] normal_x,
    input logic signed [snu_pkg::NORM_W-1:0] normal_y,
    input logic signed [snu_pkg::NORM_W-1:0] normal_z,
    input logic                              degenerate,
    input logic                              saturated
);

    // A degenerate point carries an all-zero scale and normal.
    `SNU_ASSERT_IMP(a_deg_zero, result_valid && degenerate,
        area_scale == '0 && normal_x == '0 && normal_y == '0 && normal_z == '0,
        "degenerate result with nonzero fields")

    // A saturated scale sits exactly at its maximum.
    `SNU_ASSERT_IMP(a_sat_max, result_valid && saturated,
        area_scale == snu_pkg::AREA_MAX, "saturated result below maximum")

    // A zero length cannot also saturate.
    `SNU_ASSERT_IMP(a_deg_not_sat, result_valid, !(degenerate && saturated),
        "degenerate and saturated together")

    // A stalled result transaction holds its payload.
    `SNU_ASSERT_NXT(a_hold, result_valid && !result_ready,
        result_valid && $stable(area_scale) && $stable(normal_x) && $stable(normal_y)
        && $stable(normal_z), "stalled result changed")

endmodule

bind surface_normal_unit snu_checker u_snu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .area_scale   (area_scale),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .degenerate   (degenerate),
    .saturated    (saturated)
);

// ----- sim/tb.sv -----
// Self-checking testbench of the surface normal unit: directed and random tangent vectors.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import snu_pkg::*;

    localparam int LATENCY    = 102;
    localparam int IDLE_LIMIT = 4000;
    localparam logic [1:0] DIM_1D   = 2'd1;
    localparam logic [1:0] DIM_ZERO = 2'd0;

    // One expected result.
    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [NORM_W-1:0] nx;
        logic [NORM_W-1:0] ny;
        logic [NORM_W-1:0] nz;
        logic              degen;
        logic              sat;
        logic              eob;
    } normal_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_enable = 1'b0;
    logic [1:0] cfg_data = '0;
    logic item_valid = 1'b0;
    logic item_ready;
    logic signed [IN_W-1:0] tangent_a_x = '0, tangent_a_y = '0, tangent_a_z = '0;
    logic signed [IN_W-1:0] tangent_b_x = '0, tangent_b_y = '0, tangent_b_z = '0;
    logic end_of_batch = 1'b0;
    logic result_valid;
    logic result_ready = 1'b0;
    logic [AREA_W-1:0] area_scale;
    logic signed [NORM_W-1:0] normal_x, normal_y, normal_z;
    logic degenerate, saturated, end_of_batch_out;

    logic [1:0] face_dim = DIM_RESET;
    normal_result_t pending_normals[$];
    int mismatches = 0;
    int results_seen = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    int idle_pct = 36;

    surface_normal_unit uut (.*);

    // Clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Integer square root of a 128-bit value, bit by bit.
    function automatic logic [63:0] isqrt128(logic [127:0] v);
        logic [63:0] root;
        logic [63:0] cand;
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= v)
                root = cand;
        end
        return root;
    endfunction

    // Signed Q2.30 component of c over the length.
    function automatic logic [NORM_W-1:0] unit_component(logic signed [64:0] c,
                                                          logic [63:0] len);
        logic [64:0] mag;
        logic [127:0] q;
        mag = c[64] ? -c : c;
        q = (128'(mag) << NORM_SHIFT) / 128'(len);
        return c[64] ? NORM_W'(-q) : NORM_W'(q);
    endfunction

    // Expected result for one point under the current face rule.
    function automatic normal_result_t predict_normal(
        logic signed [31:0] ax, logic signed [31:0] ay, logic signed [31:0] az,
        logic signed [31:0] bx, logic signed [31:0] by, logic signed [31:0] bz,
        logic eob);
        normal_result_t r;
        logic signed [64:0] cx, cy, cz;
        logic [127:0] sum;
        logic [63:0] len, scaled;
        r = '0;
        r.eob = eob;
        if (face_dim != DIM_2D && face_dim != DIM_3D)
        begin
            r.area = AREA_ONE;
            r.nx = NORM_MINUS_ONE;
            return r;
        end
        if (face_dim == DIM_3D)
        begin
            cx = 65'(64'(ay) * 64'(bz)) - 65'(64'(az) * 64'(by));
            cy = 65'(64'(az) * 64'(bx)) - 65'(64'(ax) * 64'(bz));
            cz = 65'(64'(ax) * 64'(by)) - 65'(64'(ay) * 64'(bx));
        end
        else
        begin
            cx = 65'(ay);
            cy = -65'(ax);
            cz = '0;
        end
        sum = 128'(cx * cx) + 128'(cy * cy) + 128'(cz * cz);
        len = isqrt128(sum);
        if (len == 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        scaled = (face_dim == DIM_3D) ? (len >> FRAC_BITS) : len;
        if (scaled > 64'(AREA_MAX))
        begin
            r.area = AREA_MAX;
            r.sat = 1'b1;
        end
        else
            r.area = AREA_W'(scaled);
        r.nx = unit_component(cx, len);
        r.ny = unit_component(cy, len);
        r.nz = unit_component(cz, len);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH result %0d %s: got %h expected %h", results_seen, what, got, want);
        mismatches++;
    endtask

    // Result checking and the receiver's stalls.
    always @(posedge clk)
    begin
        normal_result_t e;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_normals.size() == 0)
                report_mismatch("unexpected result", 0, 0);
            else
            begin
                e = pending_normals.pop_front();
                if (area_scale !== e.area) report_mismatch("area_scale", area_scale, e.area);
                if (normal_x !== e.nx) report_mismatch("normal_x", normal_x, e.nx);
                if (normal_y !== e.ny) report_mismatch("normal_y", normal_y, e.ny);
                if (normal_z !== e.nz) report_mismatch("normal_z", normal_z, e.nz);
                if (degenerate !== e.degen) report_mismatch("degenerate", degenerate, e.degen);
                if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
                if (end_of_batch_out !== e.eob)
                    report_mismatch("end_of_batch_out", end_of_batch_out, e.eob);
            end
            results_seen++;
        end
    end

    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= idle_pct);

    // Watchdog on cycles with no transaction.
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Send one point and record its expected result. Valid stays up after the
    // transaction so that the next point can follow at once; idling drops it.
    task automatic send_point(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                              logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                              logic eob);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        tangent_a_x <= ax; tangent_a_y <= ay; tangent_a_z <= az;
        tangent_b_x <= bx; tangent_b_y <= by; tangent_b_z <= bz;
        end_of_batch <= eob;
        item_valid <= 1'b1;
        pending_normals.push_back(predict_normal(ax, ay, az, bx, by, bz, eob));
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
        @(negedge clk);
    endtask

    // Wait for every result, then let the pipeline empty.
    task automatic drain_pipeline();
        item_valid <= 1'b0;
        while (pending_normals.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic set_dimension(logic [1:0] d);
        drain_pipeline();
        cfg_write_enable <= 1'b1;
        cfg_data <= d;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        face_dim = d;
    endtask

    // Random component: mixes extremes, small values and full range.
    function automatic logic [31:0] rand_component();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(8)) - 4);
            3: return 32'($signed($urandom_range(2 ** 18)) - 2 ** 17);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_points(int count);
        for (int i = 0; i < count; i++)
            send_point(rand_component(), rand_component(), rand_component(),
                       rand_component(), rand_component(), rand_component(),
                       $urandom_range(1));
    endtask

    // Directed 3D cases: unit axes, degenerate, small scale, saturation, extremes.
    task automatic test_directed_3d();
        set_dimension(DIM_3D);
        send_point(32'h1_0000, 0, 0, 0, 32'h1_0000, 0, 1'b0);
        send_point(0, 32'h1_0000, 0, 32'h1_0000, 0, 0, 1'b1);
        send_point(0, 0, 0, 0, 0, 0, 1'b0);
        send_point(32'h1_0000, 32'h2_0000, 32'h3_0000,
                   32'h2_0000, 32'h4_0000, 32'h6_0000, 1'b0);
        send_point(1, 0, 0, 0, 1, 0, 1'b1);
        send_point(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'h0, 32'h1, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    endtask

    // Directed 2D, 1D and code-zero cases.
    task automatic test_directed_low_dims();
        set_dimension(DIM_2D);
        send_point(32'h1_0000, 0, 5, 6, 7, 8, 1'b0);
        send_point(0, 0, 32'hFFFF_FFFF, 1, 1, 1, 1'b1);
        send_point(32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 1'b0);
        send_point(0, 1, 0, 0, 0, 0, 1'b1);
        set_dimension(DIM_1D);
        send_point(32'hFFFF_FFFF, 32'h8000_0000, 1, 2, 3, 4, 1'b0);
        send_point(0, 0, 0, 0, 0, 0, 1'b1);
        set_dimension(DIM_ZERO);
        send_point(32'h7FFF_FFFF, 0, 0, 0, 0, 0, 1'b1);
    endtask

    // Random phases across all face rules, with one stretch of full throughput.
    task automatic test_random();
        set_dimension(DIM_3D);
        random_points(600);
        idle_pct = 0;
        random_points(200);
        idle_pct = 36;
        set_dimension(DIM_2D);
        random_points(350);
        set_dimension(DIM_1D);
        random_points(80);
        set_dimension(DIM_ZERO);
        random_points(40);
        set_dimension(DIM_3D);
        random_points(80);
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_3d();
        test_directed_low_dims();
        test_random();
        drain_pipeline();
        $display("Sent %0d points over the 3D, 2D, 1D and code-zero face rules,", items_sent);
        $display("checked %0d results with %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
